[src/rc5w_pkg.sv]
// shared types, constants and rotate helpers for the rc5 16-bit word cipher
package rc5w_pkg;

  localparam int unsigned MaxRounds   = 24;
  localparam int unsigned MaxKeyBytes = 128;
  localparam int unsigned MinKeyBytes = 8;
  localparam int unsigned RkSlots     = 2 * (MaxRounds + 1);
  localparam int unsigned WordSlots   = MaxKeyBytes / 4;

  localparam logic [31:0] PStart = 32'hb7e15163;
  localparam logic [31:0] QStep  = 32'h9e3779b9;

  typedef enum logic [1:0] {
    MODE_KEY  = 2'd0,
    MODE_ENC  = 2'd1,
    MODE_DEC  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_ENC,
    ST_DEC
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] block_in;
  } req_t;

  typedef struct packed {
    logic [31:0] block_out;
    logic        status;
  } res_t;

  // control of one half-round of the block datapath
  typedef struct packed {
    logic dec;
    logic first;
    logic odd;
  } hr_ctrl_t;

  function automatic logic [15:0] rol16(input logic [15:0] x, input logic [3:0] r);
    logic [31:0] t;
    t = {x, x} << r;
    return t[31:16];
  endfunction

  function automatic logic [15:0] ror16(input logic [15:0] x, input logic [3:0] r);
    logic [31:0] t;
    t = {x, x} >> r;
    return t[15:0];
  endfunction

endpackage

[src/rc5w_half.sv]
// one encrypt or decrypt half-round of the block datapath
module rc5w_half import rc5w_pkg::*; (
  input  hr_ctrl_t    ctrl_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  input  logic [15:0] rk_i,
  output logic [15:0] a_o,
  output logic [15:0] b_o
);

  logic [15:0] ea, eb, da, db;

  always_comb begin
    // encrypt: whitening adds first, then data-dependent rotates
    ea = ctrl_i.first ? a_i + rk_i : rol16(a_i ^ b_i, b_i[3:0]) + rk_i;
    eb = ctrl_i.first ? b_i + rk_i : rol16(b_i ^ a_i, a_i[3:0]) + rk_i;
    da = ctrl_i.first ? a_i - rk_i : ror16(a_i - rk_i, b_i[3:0]) ^ b_i;
    db = ctrl_i.first ? b_i - rk_i : ror16(b_i - rk_i, a_i[3:0]) ^ a_i;
    a_o = a_i;
    b_o = b_i;
    if (ctrl_i.odd) begin
      b_o = ctrl_i.dec ? db : eb;
    end else begin
      a_o = ctrl_i.dec ? da : ea;
    end
  end

endmodule

[src/rc5_16bit_word_block_cipher.sv]
// rc5 with 16-bit words: key intake, key schedule and block engine
//
// Command channel: an item is taken at a clock edge with start high and
// busy low. Mode key takes one key byte; the byte with key_last set
// ends the key and runs the schedule. Modes encrypt and decrypt process
// block_in. Mode three is taken and ignored.
// Results appear on res_o for one cycle with done_o high; the receiver
// cannot stall, so every strobe is a completed transfer.
// Key byte without key_last: no result, busy stays low.
// Invalid key length (outside 8..128 bytes): result in the cycle after the
// transfer, status set.
// Schedule: 3*max(2(n+1), ceil(len/4)) mixing steps, one per cycle, result
// in the cycle after the last step.
// Encrypt/decrypt: 2n+2 half-rounds, one round-key read from the single
// read port of the round-key memory each cycle; the result is registered
// from the last half-round, n being the rounds of the last good schedule.
// The rounds register is sampled when a schedule starts.
// Reset clears control state; before the first good schedule the round
// keys read as zero and the round count is zero.
module rc5_16bit_word_block_cipher import rc5w_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output logic       done_o,
  output res_t       res_o,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [4:0]  rounds_q, active_q, rsch_q, rsch_d, r_eff;
  logic        keyed_q, keyed_d;
  logic [7:0]  key_cnt_q, key_cnt_d, lo_byte_q, lo_byte_d;
  logic [15:0] a_q, a_d, b_q, b_d;
  logic [5:0]  k_q, k_d;
  logic [7:0]  v_q, v_d, s_q, s_d;
  logic [5:0]  i_q, i_d, t_q, t_d, l_q, l_d;
  logic [4:0]  j_q, j_d;
  logic [31:0] w_q, w_d;
  logic        done_q, done_d;
  res_t        res_q, res_d;
  logic [4:0]  active_d;

  // round-key and key-word memories
  logic [15:0] rk_mem [RkSlots];
  logic [15:0] kw_mem [WordSlots];
  logic [15:0] rk_rdata_q, kw_rdata_q, rk_wdata, kw_wdata;
  logic [5:0]  rk_raddr, rk_waddr;
  logic [4:0]  kw_raddr, kw_waddr;
  logic        rk_we, kw_we;

  logic        accept;
  mode_e       mode;
  logic [8:0]  len, len3;
  logic [5:0]  t_new, l_new, mx;
  logic [15:0] rk_val, sum1, a_mix, ab, b_mix, rk_blk, a_hr, b_hr;
  logic [5:0]  i_nx;
  logic [4:0]  j_nx;
  hr_ctrl_t    hr_ctrl;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign mode   = mode_e'(req_i.mode);
  assign done_o = done_q;
  assign res_o  = res_q;

  assign r_eff = (rounds_q == 5'd0 || rounds_q > 5'(MaxRounds)) ? 5'(MaxRounds) : rounds_q;
  assign len   = {1'b0, key_cnt_q} + 9'd1;
  assign len3  = len + 9'd3;
  assign t_new = {r_eff, 1'b0} + 6'd2;
  assign l_new = len3[7:2];
  assign mx    = (t_new > l_new) ? t_new : l_new;

  // schedule mixing step
  always_comb begin
    rk_val = (v_q < {2'b00, t_q}) ? (i_q[0] ? w_q[31:16] : w_q[15:0]) : rk_rdata_q;
    sum1   = rk_val + a_q + b_q;
    a_mix  = rol16(sum1, 4'd3);
    ab     = a_mix + b_q;
    b_mix  = rol16(kw_rdata_q + ab, ab[3:0]);
    i_nx   = (i_q + 6'd1 == t_q) ? 6'd0 : i_q + 6'd1;
    j_nx   = ({1'b0, j_q} + 6'd1 == l_q) ? 5'd0 : j_q + 5'd1;
  end

  assign rk_blk        = keyed_q ? rk_rdata_q : 16'h0000;
  assign hr_ctrl.dec   = (state_q == ST_DEC);
  assign hr_ctrl.first = (k_q[5:1] == 5'd0);
  assign hr_ctrl.odd   = k_q[0];

  rc5w_half u_half (
    .ctrl_i (hr_ctrl),
    .a_i    (a_q),
    .b_i    (b_q),
    .rk_i   (rk_blk),
    .a_o    (a_hr),
    .b_o    (b_hr)
  );

  always_comb begin
    state_d   = state_q;
    keyed_d   = keyed_q;
    active_d  = active_q;
    rsch_d    = rsch_q;
    key_cnt_d = key_cnt_q;
    lo_byte_d = lo_byte_q;
    a_d = a_q;  b_d = b_q;  k_d = k_q;
    v_d = v_q;  s_d = s_q;  i_d = i_q;  j_d = j_q;
    t_d = t_q;  l_d = l_q;  w_d = w_q;
    done_d = 1'b0;
    res_d  = '0;
    rk_raddr = 6'd0;  kw_raddr = 5'd0;
    rk_we = 1'b0;  rk_waddr = i_q;  rk_wdata = a_mix;
    kw_we = 1'b0;  kw_waddr = j_q;  kw_wdata = b_mix;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_KEY: begin
              // bytes 0 and 1 of each group build the key word
              if (key_cnt_q < 8'(MaxKeyBytes)) begin
                kw_waddr = key_cnt_q[6:2];
                if (key_cnt_q[1:0] == 2'd0) begin
                  kw_we     = 1'b1;
                  kw_wdata  = {8'h00, req_i.key_byte};
                  lo_byte_d = req_i.key_byte;
                end else if (key_cnt_q[1:0] == 2'd1) begin
                  kw_we    = 1'b1;
                  kw_wdata = {req_i.key_byte, lo_byte_q};
                end
              end
              if (!req_i.key_last) begin
                if (key_cnt_q != 8'hff) key_cnt_d = key_cnt_q + 8'd1;
              end else begin
                key_cnt_d = 8'd0;
                if (len < 9'(MinKeyBytes) || len > 9'(MaxKeyBytes)) begin
                  done_d       = 1'b1;
                  res_d.status = 1'b1;
                end else begin
                  state_d = ST_SCHED;
                  t_d = t_new;  l_d = l_new;
                  s_d = {1'b0, mx, 1'b0} + {2'b00, mx};
                  rsch_d = r_eff;
                  v_d = 8'd0;  i_d = 6'd0;  j_d = 5'd0;
                  a_d = 16'h0000;  b_d = 16'h0000;
                  w_d = PStart;
                end
              end
            end
            MODE_ENC: begin
              state_d = ST_ENC;
              k_d = 6'd0;
              a_d = req_i.block_in[15:0];
              b_d = req_i.block_in[31:16];
            end
            MODE_DEC: begin
              state_d  = ST_DEC;
              k_d      = {active_q, 1'b1};
              rk_raddr = {active_q, 1'b1};
              a_d = req_i.block_in[15:0];
              b_d = req_i.block_in[31:16];
            end
            default: ;
          endcase
        end
      end
      ST_SCHED: begin
        rk_we = 1'b1;
        kw_we = 1'b1;
        a_d = a_mix;
        b_d = b_mix;
        if (i_q[0]) w_d = w_q + QStep;
        i_d = i_nx;
        j_d = j_nx;
        rk_raddr = i_nx;
        kw_raddr = j_nx;
        v_d = v_q + 8'd1;
        if (v_q == s_q - 8'd1) begin
          state_d  = ST_IDLE;
          active_d = rsch_q;
          keyed_d  = 1'b1;
          done_d   = 1'b1;
        end
      end
      ST_ENC: begin
        a_d = a_hr;
        b_d = b_hr;
        if (k_q == {active_q, 1'b1}) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          res_d.block_out = {b_hr, a_hr};
        end else begin
          k_d      = k_q + 6'd1;
          rk_raddr = k_q + 6'd1;
        end
      end
      ST_DEC: begin
        a_d = a_hr;
        b_d = b_hr;
        if (k_q == 6'd0) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          res_d.block_out = {b_hr, a_hr};
        end else begin
          k_d      = k_q - 6'd1;
          rk_raddr = k_q - 6'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
    rk_rdata_q <= rk_mem[rk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (kw_we) kw_mem[kw_waddr] <= kw_wdata;
    kw_rdata_q <= kw_mem[kw_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rounds_q  <= 5'd0;
      active_q  <= 5'd0;
      keyed_q   <= 1'b0;
      key_cnt_q <= 8'd0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) rounds_q <= cfg_data_i;
      active_q  <= active_d;
      keyed_q   <= keyed_d;
      key_cnt_q <= key_cnt_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsch_q    <= rsch_d;
    lo_byte_q <= lo_byte_d;
    a_q <= a_d;  b_q <= b_d;  k_q <= k_d;
    v_q <= v_d;  s_q <= s_d;  i_q <= i_d;  j_q <= j_d;
    t_q <= t_d;  l_q <= l_d;  w_q <= w_d;
    res_q <= res_d;
  end

  // a block transfer always occupies the engine on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode == MODE_ENC || mode == MODE_DEC) |=> busy)
    else $error("block transfer did not start the engine");

  // a failed key never carries block data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status |-> res_o.block_out == 32'h0)
    else $error("invalid key result with block data");

  // encrypt never reads past the active round keys
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ENC |-> k_q <= {active_q, 1'b1})
    else $error("encrypt index beyond active rounds");

  // a finished schedule leaves the table marked as keyed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCHED && state_d == ST_IDLE |=> keyed_q)
    else $error("schedule completed without keying");

endmodule

[bench/rc5_16bit_word_block_cipher_chk.sv]
// checker: predicts the rc5 16-bit word cipher results and compares them
`timescale 1ns / 100ps
module rc5_16bit_word_block_cipher_chk import rc5w_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  req_t       req_i,
  input  logic       done_i,
  input  res_t       res_i,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i,
  output int         fail_cnt_o,
  output int         pending_o
);

  logic [7:0]  key_bytes [MaxKeyBytes];
  logic [7:0]  key_cnt;
  logic [15:0] sched_words [WordSlots];
  logic [15:0] rk [RkSlots];
  int unsigned cur_rounds;
  logic [4:0]  rounds_reg;
  res_t        expected_q [$];

  function automatic logic [15:0] rotl(logic [15:0] x, logic [15:0] r);
    int unsigned s;
    s = r[3:0];
    return (s == 0) ? x : ((x << s) | (x >> (16 - s)));
  endfunction

  function automatic logic [15:0] rotr(logic [15:0] x, logic [15:0] r);
    int unsigned s;
    s = r[3:0];
    return (s == 0) ? x : ((x >> s) | (x << (16 - s)));
  endfunction

  function automatic logic [15:0] init_half(int unsigned k);
    logic [31:0] w;
    w = PStart + (k >> 1) * QStep;
    return (k & 1) ? w[31:16] : w[15:0];
  endfunction

  function automatic logic run_schedule(int unsigned len);
    int unsigned r, t, l, s, i, j;
    logic [15:0] a, b;
    if (len < MinKeyBytes || len > MaxKeyBytes) return 1'b1;
    r = rounds_reg;
    if (r == 0) r = MaxRounds;
    if (r > MaxRounds) r = MaxRounds;
    l = (len + 3) / 4;
    for (j = 0; j < l; j++) begin
      sched_words[j] = '0;
      if (4*j < len) sched_words[j][7:0] = key_bytes[4*j];
      if (4*j+1 < len) sched_words[j][15:8] = key_bytes[4*j+1];
    end
    t = 2 * (r + 1);
    for (i = 0; i < t; i++) rk[i] = init_half(i);
    s = 3 * ((t > l) ? t : l);
    a = '0; b = '0; i = 0; j = 0;
    repeat (s) begin
      a = rotl(rk[i] + a + b, 16'd3);
      rk[i] = a;
      b = rotl(sched_words[j] + a + b, a + b);
      sched_words[j] = b;
      i = (i + 1 >= t) ? 0 : i + 1;
      j = (j + 1 >= l) ? 0 : j + 1;
    end
    cur_rounds = r;
    return 1'b0;
  endfunction

  function automatic logic [31:0] encrypt(logic [31:0] blk);
    logic [15:0] a, b;
    a = blk[15:0] + rk[0];
    b = blk[31:16] + rk[1];
    for (int unsigned r = 1; r <= cur_rounds; r++) begin
      a = rotl(a ^ b, b) + rk[2*r];
      b = rotl(b ^ a, a) + rk[2*r+1];
    end
    return {b, a};
  endfunction

  function automatic logic [31:0] decrypt(logic [31:0] blk);
    logic [15:0] a, b;
    a = blk[15:0];
    b = blk[31:16];
    for (int unsigned r = cur_rounds; r >= 1; r--) begin
      b = rotr(b - rk[2*r+1], a) ^ a;
      a = rotr(a - rk[2*r], b) ^ b;
    end
    a = a - rk[0];
    b = b - rk[1];
    return {b, a};
  endfunction

  task automatic predict(req_t rq);
    res_t e;
    e = '0;
    case (mode_e'(rq.mode))
      MODE_KEY: begin
        if (key_cnt < MaxKeyBytes) key_bytes[key_cnt] = rq.key_byte;
        if (!rq.key_last) begin
          if (key_cnt != 8'hff) key_cnt++;
        end else begin
          e.status = run_schedule(int'(key_cnt) + 1);
          key_cnt = '0;
          expected_q.push_back(e);
        end
      end
      MODE_ENC: begin
        e.block_out = encrypt(rq.block_in);
        expected_q.push_back(e);
      end
      MODE_DEC: begin
        e.block_out = decrypt(rq.block_in);
        expected_q.push_back(e);
      end
      default: ;
    endcase
  endtask

  initial begin
    fail_cnt_o = 0;
    pending_o = 0;
    key_cnt = '0;
    cur_rounds = 0;
    rounds_reg = '0;
    for (int n = 0; n < RkSlots; n++) rk[n] = '0;
    for (int n = 0; n < MaxKeyBytes; n++) key_bytes[n] = '0;
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h/%0d",
                   $time, res_i.block_out, res_i.status);
          fail_cnt_o++;
        end else begin
          e = expected_q.pop_front();
          if (res_i.block_out !== e.block_out) begin
            $display("%0t: block_out: expected %h, actual %h", $time, e.block_out,
                     res_i.block_out);
            fail_cnt_o++;
          end
          if (res_i.status !== e.status) begin
            $display("%0t: status: expected %0d, actual %0d", $time, e.status,
                     res_i.status);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_we_i) rounds_reg = cfg_data_i;
      if (start_i && !busy_i) predict(req_i);
      pending_o = expected_q.size();
    end
  end

endmodule

[bench/rc5_16bit_word_block_cipher_tb.sv]
// testbench top: drives commands and rounds settings, gives the verdict
`timescale 1ns / 100ps
module rc5_16bit_word_block_cipher_tb import rc5w_pkg::*;;

  logic       clk, rst_n, start, busy, done, cfg_we;
  logic [4:0] cfg_data;
  req_t       req;
  res_t       res;
  int         fail_cnt, pending, idle_cycles;
  bit         timed_out;

  localparam int IdleLimit = 4000;

  rc5_16bit_word_block_cipher i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy), .req_i(req),
    .done_o(done), .res_o(res), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data)
  );

  rc5_16bit_word_block_cipher_chk i_chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .req_i(req),
    .done_i(done), .res_i(res), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || done || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Mismatches found");
      $finish;
    end
  end

  // returns at the accepting edge with start still high
  task automatic send(req_t rq);
    int gap;
    gap = $urandom_range(0, 14);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= rq;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic stop_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic send_key_byte(logic [7:0] b, logic last);
    req_t rq;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    rq = rnd[$bits(req_t)-1:0];
    rq.mode = MODE_KEY;
    rq.key_byte = b;
    rq.key_last = last;
    send(rq);
  endtask

  task automatic send_key(int len);
    for (int n = 0; n < len; n++)
      send_key_byte(8'($urandom_range(0, 255)), n == len - 1);
  endtask

  task automatic send_block(mode_e m, logic [31:0] blk);
    req_t rq;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    rq = rnd[$bits(req_t)-1:0];
    rq.mode = m;
    rq.block_in = blk;
    send(rq);
  endtask

  // wait for all results, then for the engine to settle before a rounds write
  task automatic drain_and_set(logic [4:0] r);
    stop_start();
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= r;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int   len, items;
    req_t rq;
    logic [63:0] rnd;
    timed_out = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    req = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // cleared table first
    send_block(MODE_ENC, 32'h0000_0000);
    send_block(MODE_DEC, 32'hffff_ffff);
    rq = '1;
    send(rq);
    send_key(3);
    send_key(130);
    drain_and_set(5'd1);
    send_key(8);
    send_block(MODE_ENC, 32'hffff_ffff);
    send_block(MODE_DEC, 32'h0000_0000);
    send_key_byte(8'hff, 1'b0);
    send_key_byte(8'h00, 1'b0);
    send_key(7);
    send_block(MODE_ENC, 32'h1234_5678);
    drain_and_set(5'd31);
    send_key(128);
    send_block(MODE_ENC, 32'h8000_0001);
    send_block(MODE_DEC, 32'h7fff_fffe);
    drain_and_set(5'd24);
    send_key(129);

    items = 0;
    while (items < 940) begin
      if ($urandom_range(0, 9) == 0) begin
        drain_and_set(($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 1) * 31)
                                                  : 5'($urandom_range(0, 31)));
        case ($urandom_range(0, 9))
          0: len = $urandom_range(1, 7);
          1: len = $urandom_range(100, 140);
          default: len = $urandom_range(8, 20);
        endcase
        send_key(len);
        items += len;
      end else begin
        rnd = {$urandom, $urandom};
        rq = rnd[$bits(req_t)-1:0];
        rq.mode = ($urandom_range(0, 19) == 0) ? MODE_NONE
                : ($urandom_range(0, 1) ? MODE_ENC : MODE_DEC);
        if ($urandom_range(0, 29) == 0) rq.mode = MODE_KEY;
        send(rq);
        items++;
      end
    end

    stop_start();
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[rc5_16bit_word_block_cipher.f]
src/rc5w_pkg.sv
src/rc5w_half.sv
src/rc5_16bit_word_block_cipher.sv
bench/rc5_16bit_word_block_cipher_chk.sv
bench/rc5_16bit_word_block_cipher_tb.sv
